@@ rtl/core/dsme_pkg.sv @@
package dsme_pkg;

  localparam int unsigned EXP_BITS_DEF = 32;
  localparam int unsigned EXP_OUT_W    = 32;
  localparam int unsigned MANT_W       = 64;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned IN_DATA_W    = 8;
  localparam int unsigned OUT_DATA_W   = 104;

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_SIGNED  = 4'd1,
    PH_ZERO    = 4'd2,
    PH_INT     = 4'd3,
    PH_DOT     = 4'd4,
    PH_FRAC    = 4'd5,
    PH_EXPMARK = 4'd6,
    PH_EXPSIGN = 4'd7,
    PH_EXPDIG  = 4'd8,
    PH_BAD     = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NAN  = 2'd1,
    ST_MOVF = 2'd2,
    ST_EOVF = 2'd3
  } status_t;

  typedef struct packed {
    status_t                status;
    logic [MANT_W-1:0]      mantissa;
    logic [EXP_OUT_W-1:0]   exponent;
    logic                   is_negative;
  } result_t;

endpackage

@@ rtl/core/dsme_parse.sv @@
module dsme_parse #(
  parameter int unsigned EXPONENT_BITS = dsme_pkg::EXP_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [dsme_pkg::CHAR_W-1:0] chr,
  input  logic                        term,
  output dsme_pkg::result_t           res
);
  import dsme_pkg::*;

  localparam int unsigned EB = EXPONENT_BITS;

  phase_t              phase_r, phase_nxt;
  logic [MANT_W-1:0]   acc_r, acc_nxt;
  logic [EB-1:0]       frac_r, frac_nxt;
  logic [EB-2:0]       expl_r, expl_nxt;
  logic                sign_r, sign_nxt;
  logic                eminus_r, eminus_nxt;
  status_t             err_r, err_nxt;

  logic                is_dig, is_pm, is_exp, is_dot, is_zero;
  logic [3:0]          dval;
  logic [MANT_W+3:0]   acc_ext, m10;
  logic                movf;
  logic [EB+2:0]       expl_ext, v10;
  logic                eovf_x;
  logic signed [EB+1:0] e_full;
  logic signed [EB-1:0] e_trunc;
  logic                e_in_range;
  logic                accepting;
  status_t             fin_err;

  function automatic status_t raise(status_t cur, status_t code);
    status_t r;
    r = cur;
    if (code == ST_NAN || cur == ST_OK) r = code;
    else if (code == ST_MOVF && cur == ST_EOVF) r = code;
    return r;
  endfunction

  assign is_dig  = (chr >= "0") && (chr <= "9");
  assign is_zero = (chr == "0");
  assign is_pm   = (chr == "+") || (chr == "-");
  assign is_exp  = (chr == "e") || (chr == "E");
  assign is_dot  = (chr == ".");
  assign dval    = chr[3:0];

  assign acc_ext = {4'b0, acc_r};
  assign m10     = (acc_ext << 3) + (acc_ext << 1) + {{MANT_W{1'b0}}, dval};
  assign movf    = |m10[MANT_W+3:MANT_W];

  assign expl_ext = {4'b0, expl_r};
  assign v10      = (expl_ext << 3) + (expl_ext << 1) + {{(EB-1){1'b0}}, dval};
  assign eovf_x   = |v10[EB+2:EB-1];

  // final exponent: +/- explicit minus fraction digit count
  assign e_full = (eminus_r ? -$signed({3'b0, expl_r}) : $signed({3'b0, expl_r}))
                  - $signed({2'b0, frac_r});
  assign e_trunc    = e_full[EB-1:0];
  assign e_in_range = (&e_full[EB+1:EB-1]) || !(|e_full[EB+1:EB-1]);

  assign accepting = (phase_r == PH_ZERO) || (phase_r == PH_INT) ||
                     (phase_r == PH_FRAC) || (phase_r == PH_EXPDIG);

  always_comb begin
    fin_err = accepting ? err_r : raise(err_r, ST_NAN);
    if (fin_err == ST_OK && !e_in_range) fin_err = ST_EOVF;
    res.status      = fin_err;
    res.mantissa    = (fin_err == ST_OK) ? acc_r : '0;
    res.exponent    = (fin_err == ST_OK) ? EXP_OUT_W'(e_trunc) : '0;
    res.is_negative = (fin_err == ST_OK) ? sign_r : 1'b0;
  end

  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    frac_nxt   = frac_r;
    expl_nxt   = expl_r;
    sign_nxt   = sign_r;
    eminus_nxt = eminus_r;
    err_nxt    = err_r;
    unique case (phase_r)
      PH_START, PH_SIGNED: begin
        if (phase_r == PH_START && is_pm) begin
          sign_nxt  = (chr == "-");
          phase_nxt = PH_SIGNED;
        end else if (is_zero) begin
          phase_nxt = PH_ZERO;
        end else if (is_dig) begin
          acc_nxt   = m10[MANT_W-1:0];
          phase_nxt = PH_INT;
        end else begin
          err_nxt   = raise(err_r, ST_NAN);
          phase_nxt = PH_BAD;
        end
      end
      PH_ZERO, PH_INT: begin
        if (is_dig && phase_r == PH_INT) begin
          if (err_r != ST_MOVF) begin
            if (movf) err_nxt = raise(err_r, ST_MOVF);
            else      acc_nxt = m10[MANT_W-1:0];
          end
        end else if (is_dot) begin
          phase_nxt = PH_DOT;
        end else if (is_exp) begin
          phase_nxt = PH_EXPMARK;
        end else begin
          err_nxt   = raise(err_r, ST_NAN);
          phase_nxt = PH_BAD;
        end
      end
      PH_DOT, PH_FRAC: begin
        if (is_dig) begin
          if (err_r != ST_MOVF) begin
            if (movf) err_nxt = raise(err_r, ST_MOVF);
            else      acc_nxt = m10[MANT_W-1:0];
          end
          if (&frac_r) err_nxt = raise((err_r != ST_MOVF && movf) ? ST_MOVF : err_r,
                                       ST_EOVF);
          else         frac_nxt = frac_r + 1'b1;
          phase_nxt = PH_FRAC;
        end else if (is_exp && phase_r == PH_FRAC) begin
          phase_nxt = PH_EXPMARK;
        end else begin
          err_nxt   = raise(err_r, ST_NAN);
          phase_nxt = PH_BAD;
        end
      end
      PH_EXPMARK, PH_EXPSIGN, PH_EXPDIG: begin
        if (phase_r == PH_EXPMARK && is_pm) begin
          eminus_nxt = (chr == "-");
          phase_nxt  = PH_EXPSIGN;
        end else if (is_dig) begin
          if (eovf_x) begin
            err_nxt  = raise(err_r, ST_EOVF);
            expl_nxt = '1;
          end else begin
            expl_nxt = v10[EB-2:0];
          end
          phase_nxt = PH_EXPDIG;
        end else begin
          err_nxt   = raise(err_r, ST_NAN);
          phase_nxt = PH_BAD;
        end
      end
      default: begin
        err_nxt   = raise(err_r, ST_NAN);
        phase_nxt = PH_BAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      acc_r    <= '0;
      frac_r   <= '0;
      expl_r   <= '0;
      sign_r   <= 1'b0;
      eminus_r <= 1'b0;
      err_r    <= ST_OK;
    end else if (step) begin
      if (term) begin
        phase_r  <= PH_START;
        acc_r    <= '0;
        frac_r   <= '0;
        expl_r   <= '0;
        sign_r   <= 1'b0;
        eminus_r <= 1'b0;
        err_r    <= ST_OK;
      end else begin
        phase_r  <= phase_nxt;
        acc_r    <= acc_nxt;
        frac_r   <= frac_nxt;
        expl_r   <= expl_nxt;
        sign_r   <= sign_nxt;
        eminus_r <= eminus_nxt;
        err_r    <= err_nxt;
      end
    end
  end

endmodule

@@ rtl/core/decimal_string_to_mantissa_exponent_top.sv @@
// Decimal number string parser.
// Input stream: one character per beat in in_tdata[7:0]; a beat with in_tlast
// high ends the string, its tdata is ignored, and it produces one result beat.
// Output stream: one beat per string with status, 64-bit mantissa, exponent
// (fraction digits already subtracted) and sign. Status 0 ok, 1 not a number,
// 2 mantissa overflow, 3 exponent overflow; fields other than status are zero
// unless status is 0.
// Throughput: one beat per cycle while in_tready is high. Each character
// updates the parse state in the cycle it is accepted (multiply by ten, add,
// phase update). A result is registered when its terminating beat is taken.
// A two-entry output buffer (output register plus skid register) lets input
// beats keep flowing while a result waits; in_tready drops only when both
// entries hold results the receiver has not taken.
// Reset (rst_n low, synchronous) clears the parse state and empties the
// output buffer.
module decimal_string_to_mantissa_exponent_top #(
  parameter int unsigned EXPONENT_BITS = dsme_pkg::EXP_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dsme_pkg::IN_DATA_W-1:0]  in_tdata,  // [7:0] character
  input  logic                            in_tlast,  // terminator
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] status, [65:2] mantissa_value, [97:66] exponent_value,
  // [98] is_negative, [103:99] zero
  output logic [dsme_pkg::OUT_DATA_W-1:0] out_tdata
);
  import dsme_pkg::*;

  localparam int unsigned RES_W = $bits(result_t);

  result_t res_new;
  result_t out_r, skid_r;
  logic    out_valid_r, skid_valid_r;
  logic    in_acc, push, pop;

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign push      = in_acc && in_tlast;
  assign pop       = out_valid_r && out_tready;

  dsme_parse #(
    .EXPONENT_BITS(EXPONENT_BITS)
  ) u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (in_acc),
    .chr   (in_tdata[CHAR_W-1:0]),
    .term  (in_tlast),
    .res   (res_new)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || pop) begin
      out_valid_r <= push;
      if (push) out_r <= res_new;
    end else if (push) begin
      skid_r       <= res_new;
      skid_valid_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - RES_W)'(0), out_r.is_negative, out_r.exponent,
                       out_r.mantissa, out_r.status};

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_error_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != ST_OK) |->
      (out_r.mantissa == '0 && out_r.exponent == '0 && !out_r.is_negative))
    else $error("nonzero fields on error result");

  a_result_follows_term: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !skid_valid_r && !push) |=> !out_valid_r)
    else $error("result appeared without terminating beat");

endmodule

@@ verif/tb_decimal_string_to_mantissa_exponent_top.sv @@
module tb_decimal_string_to_mantissa_exponent_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dsme_pkg::*;

  localparam int EXPB = EXP_BITS_DEF;
  localparam longint EXP_HI = (longint'(1) << (EXPB - 1)) - 1;
  localparam longint EXP_LO = -EXP_HI - 1;
  localparam logic [63:0] FRAC_CAP = (64'd1 << EXPB) - 1;
  localparam logic [63:0] MANT_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic [7:0] text_t[$];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  decimal_string_to_mantissa_exponent_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // parser shadow state
  phase_t      sh_phase;
  logic [63:0] sh_mant;
  logic [31:0] sh_frac_cnt;
  logic [31:0] sh_exp_mag;
  logic        sh_neg;
  logic        sh_exp_neg;
  status_t     sh_err;

  result_t pending_results[$];
  result_t want;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int beats_sent = 0;
  int strings_sent = 0;
  int results_checked = 0;
  int cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void clear_parse();
    sh_phase    = PH_START;
    sh_mant     = '0;
    sh_frac_cnt = '0;
    sh_exp_mag  = '0;
    sh_neg      = 1'b0;
    sh_exp_neg  = 1'b0;
    sh_err      = ST_OK;
  endfunction

  // syntax beats mantissa overflow beats exponent overflow
  function automatic void note_error(status_t code);
    if (code == ST_NAN || sh_err == ST_OK)
      sh_err = code;
    else if (code == ST_MOVF && sh_err == ST_EOVF)
      sh_err = code;
  endfunction

  function automatic void bad_syntax();
    note_error(ST_NAN);
    sh_phase = PH_BAD;
  endfunction

  function automatic void mant_digit(logic [63:0] d);
    if (sh_err == ST_MOVF)
      return;
    if (sh_mant > (MANT_MAX - d) / 10)
      note_error(ST_MOVF);
    else
      sh_mant = sh_mant * 10 + d;
  endfunction

  function automatic void exp_digit(logic [63:0] d);
    logic [63:0] v;
    v = {32'b0, sh_exp_mag} * 10 + d;
    if (v > 64'(EXP_HI)) begin
      note_error(ST_EOVF);
      sh_exp_mag = 32'(EXP_HI);
    end else begin
      sh_exp_mag = v[31:0];
    end
  endfunction

  function automatic void track_char(logic [7:0] ch, logic last);
    logic        is_dig;
    logic        is_e;
    logic [63:0] d;
    longint      e_val;
    result_t     r;
    is_dig = (ch >= "0" && ch <= "9");
    is_e   = (ch == "e" || ch == "E");
    d      = is_dig ? {56'b0, ch - 8'h30} : 64'd0;
    if (last) begin
      e_val = 0;
      if (!(sh_phase == PH_ZERO || sh_phase == PH_INT ||
            sh_phase == PH_FRAC || sh_phase == PH_EXPDIG))
        note_error(ST_NAN);
      if (sh_err == ST_OK) begin
        e_val = sh_exp_neg ? -longint'(sh_exp_mag) : longint'(sh_exp_mag);
        e_val = e_val - longint'(sh_frac_cnt);
        if (e_val < EXP_LO || e_val > EXP_HI)
          note_error(ST_EOVF);
      end
      r = '0;
      r.status = sh_err;
      if (sh_err == ST_OK) begin
        r.mantissa    = sh_mant;
        r.exponent    = e_val[31:0];
        r.is_negative = sh_neg;
      end
      pending_results.push_back(r);
      clear_parse();
      return;
    end
    case (sh_phase)
      PH_START, PH_SIGNED: begin
        if (sh_phase == PH_START && (ch == "+" || ch == "-")) begin
          sh_neg   = (ch == "-");
          sh_phase = PH_SIGNED;
        end else if (ch == "0") begin
          sh_phase = PH_ZERO;
        end else if (is_dig) begin
          mant_digit(d);
          sh_phase = PH_INT;
        end else begin
          bad_syntax();
        end
      end
      PH_ZERO, PH_INT: begin
        if (is_dig && sh_phase == PH_INT)
          mant_digit(d);
        else if (ch == ".")
          sh_phase = PH_DOT;
        else if (is_e)
          sh_phase = PH_EXPMARK;
        else
          bad_syntax();
      end
      PH_DOT, PH_FRAC: begin
        if (is_dig) begin
          mant_digit(d);
          if ({32'b0, sh_frac_cnt} >= FRAC_CAP)
            note_error(ST_EOVF);
          else
            sh_frac_cnt++;
          sh_phase = PH_FRAC;
        end else if (is_e && sh_phase == PH_FRAC) begin
          sh_phase = PH_EXPMARK;
        end else begin
          bad_syntax();
        end
      end
      PH_EXPMARK, PH_EXPSIGN, PH_EXPDIG: begin
        if (sh_phase == PH_EXPMARK && (ch == "+" || ch == "-")) begin
          sh_exp_neg = (ch == "-");
          sh_phase   = PH_EXPSIGN;
        end else if (is_dig) begin
          exp_digit(d);
          sh_phase = PH_EXPDIG;
        end else begin
          bad_syntax();
        end
      end
      default: bad_syntax();
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending, tdata %h", out_tdata));
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[1:0] != want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_tdata[1:0], want.status));
        if (out_tdata[65:2] != want.mantissa)
          report_mismatch($sformatf("mantissa %0d, want %0d", out_tdata[65:2], want.mantissa));
        if (out_tdata[97:66] != want.exponent)
          report_mismatch($sformatf("exponent %0d, want %0d",
                                    $signed(out_tdata[97:66]), $signed(want.exponent)));
        if (out_tdata[98] != want.is_negative)
          report_mismatch($sformatf("is_negative %0b, want %0b",
                                    out_tdata[98], want.is_negative));
        if (out_tdata[103:99] != '0)
          report_mismatch($sformatf("pad bits %b not zero", out_tdata[103:99]));
        results_checked++;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_beat(input logic [7:0] ch, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_char(ch, last);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_chars(input text_t s);
    foreach (s[i]) send_beat(s[i], 1'b0);
    send_beat(8'($urandom_range(255)), 1'b1);
    strings_sent++;
  endtask

  task automatic send_text(input string txt);
    text_t s;
    s = {};
    for (int i = 0; i < txt.len(); i++) s.push_back(txt[i]);
    send_chars(s);
  endtask

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(9));
  endfunction

  function automatic text_t make_number();
    text_t s;
    int n;
    int pick;
    string edge_txt;
    s = {};
    n = 0;
    edge_txt = "184467440737095516";
    pick = $urandom_range(2);
    if (pick == 1) s.push_back("+");
    else if (pick == 2) s.push_back("-");
    if ($urandom_range(7) == 0) begin
      s.push_back("0");
    end else begin
      pick = $urandom_range(9);
      if (pick == 0) begin
        for (int i = 0; i < edge_txt.len(); i++) s.push_back(edge_txt[i]);
        n = 2;
      end else begin
        s.push_back(8'h31 + 8'($urandom_range(8)));
        n = (pick == 1) ? $urandom_range(16, 20) : $urandom_range(0, 6);
      end
      repeat (n) s.push_back(rand_digit());
    end
    if ($urandom_range(1)) begin
      s.push_back(".");
      n = ($urandom_range(9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 5);
      repeat (n) s.push_back(rand_digit());
    end
    if ($urandom_range(4) < 2) begin
      s.push_back($urandom_range(1) ? "e" : "E");
      pick = $urandom_range(2);
      if (pick == 1) s.push_back("+");
      else if (pick == 2) s.push_back("-");
      pick = $urandom_range(9);
      if (pick == 0) begin
        edge_txt = "214748364";
        for (int i = 0; i < edge_txt.len(); i++) s.push_back(edge_txt[i]);
        s.push_back(rand_digit());
      end else begin
        n = (pick == 1) ? $urandom_range(10, 11) : $urandom_range(1, 4);
        repeat (n) s.push_back(rand_digit());
      end
    end
    return s;
  endfunction

  function automatic text_t damage(input text_t s);
    int pos;
    int keep;
    string marks;
    marks = "0.eE+-";
    pos = $urandom_range(s.size());
    case ($urandom_range(4))
      0: s.insert(pos, 8'($urandom_range(255)));
      1: begin
        keep = $urandom_range(s.size());
        while (s.size() > keep) void'(s.pop_back());
      end
      2: if (s.size() > 0) s[$urandom_range(s.size() - 1)] = 8'($urandom_range(255));
      3: begin
        s = {};
        repeat ($urandom_range(6)) s.push_back(8'($urandom_range(255)));
      end
      default: s.insert(pos, marks[$urandom_range(marks.len() - 1)]);
    endcase
    return s;
  endfunction

  task automatic test_valid_forms();
    send_text("0");
    send_text("-0");
    send_text("+7");
    send_text("123.450");
    send_text("-9.99e+12");
    send_text("5E-3");
    send_text("0e0");
    send_text("0.0001E7");
    send_text("18446744073709551615");
    send_text("1e2147483647");
    send_text("-1e-2147483647");
    send_text("1.5e-2147483647");
  endtask

  task automatic test_syntax_errors();
    send_text("");
    send_text("01");
    send_text("1.");
    send_text(".5");
    send_text("1e");
    send_text("1e+");
    send_text("-");
    send_text("+-1");
    send_text("1.e5");
    send_text("0x1");
    send_text("0.5e5.1");
    send_chars('{8'h00});
    send_chars('{"1", 8'hFF, "2"});
  endtask

  task automatic test_overflow_and_priority();
    send_text("18446744073709551616");
    send_text("1e2147483648");
    send_text("1.0e-2147483648");
    send_text("1.55e-2147483647");
    send_text("99999999999999999999e99999999999");
    send_text("99999999999999999999e1x");
    send_text("1e99999999999.");
  endtask

  task automatic test_random_strings(input int beats);
    text_t s;
    int target;
    target = beats_sent + beats;
    while (beats_sent < target) begin
      s = make_number();
      if ($urandom_range(99) < 25) s = damage(s);
      send_chars(s);
    end
  endtask

  initial begin
    clear_parse();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct  = 30;
    recv_stall_pct = 55;
    test_valid_forms();
    test_syntax_errors();
    test_overflow_and_priority();
    test_random_strings(80);

    send_idle_pct  = 55;
    recv_stall_pct = 30;
    test_random_strings(80);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_strings(80);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d strings in %0d character beats, checked %0d results",
             strings_sent, beats_sent, results_checked);
    $display("directed forms, syntax errors, overflow limits and random numbers, %0d mismatches",
             mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
